>>> rtl/ucdw_pkg.sv
// ----------------------------------------------------------------------------
// ucdw_pkg: shared types and constants
// Transaction payloads, result kinds, status codes and descriptor type codes
// for the configuration descriptor walker.
// ----------------------------------------------------------------------------
package ucdw_pkg;

   // Result kinds
   localparam logic [1:0] KIND_INTERFACE = 2'd0;
   localparam logic [1:0] KIND_ENDPOINT  = 2'd1;
   localparam logic [1:0] KIND_SUMMARY   = 2'd2;

   // status_and_last codes
   localparam logic [1:0] STATUS_NONE      = 2'd0;
   localparam logic [1:0] STATUS_LAST_OK   = 2'd1;
   localparam logic [1:0] STATUS_LAST_SHORT = 2'd3;

   // Standard descriptor type codes
   localparam logic [7:0] DTYPE_INTERFACE = 8'd4;
   localparam logic [7:0] DTYPE_ENDPOINT  = 8'd5;

   // Minimum configuration header length and minimum useful descriptor lengths
   localparam logic [7:0] HEADER_MIN     = 8'd9;
   localparam logic [7:0] IF_LEN_MIN     = 8'd8;
   localparam logic [7:0] EP_LEN_MIN     = 8'd7;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  class_code;
      logic [7:0]  subclass_code;
      logic [7:0]  protocol_code;
      logic        interface_seen;
      logic [3:0]  ep_slot;
      logic [7:0]  ep_address;
      logic [7:0]  ep_attributes;
      logic [15:0] ep_max_packet;
      logic [7:0]  ep_interval;
      logic [4:0]  ep_count;
      logic [1:0]  status_and_last;
   } rsp_type;

endpackage

>>> rtl/usb_config_descriptor_walker.sv
// ----------------------------------------------------------------------------
// usb_config_descriptor_walker: USB configuration descriptor walker
// Skips the configuration header, walks the length/type chain and reports
// interface codes, endpoint records and a per-set summary.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake          payload
//   req_*    in         valid / stall      req_type: one buffer byte + last mark
//   rsp_*    out        valid / stall      rsp_type: interface, endpoint, summary
//
// One byte per cycle while the queue has room: a byte enters the input register,
// is walked and its results (up to two) land in a 4-entry result queue.
// The input register advances while the queue has room for two results.
// Reset is synchronous and returns the walker to the start of a set.
// A stalled rsp side fills the queue and then backs up into req_stall.
// ----------------------------------------------------------------------------
module usb_config_descriptor_walker
   import ucdw_pkg::*;
#(
   parameter int MAX_ENDPOINTS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int EpCntW = $clog2(MAX_ENDPOINTS + 1);
   localparam int Depth  = 4;
   localparam int PtrW   = 2;
   localparam int CntW   = 3;
   localparam logic [3:0] PosSat = 4'd9;

   // Input register
   logic    in_valid_ff, in_valid_in;
   req_type in_ff;

   // Walker state
   logic [3:0]        pos_ff, pos_in;
   logic [7:0]        hdr_ff, hdr_in;
   logic [7:0]        len_ff, len_in;
   logic [7:0]        dtype_ff, dtype_in;
   logic [7:0]        off_ff, off_in;
   logic [39:0]       cap_ff, cap_in;
   logic              stop_ff, stop_in;
   logic [EpCntW-1:0] epcnt_ff, epcnt_in;
   logic [23:0]       codes_ff, codes_in;
   logic              found_ff, found_in;

   // Result queue
   rsp_type          fifo_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]  fifo_cnt_ff;
   logic [PtrW-1:0]  sum_ptr;

   logic    adv;
   logic    pop;
   logic    desc_v, sum_v;
   rsp_type desc_r, sum_r;
   logic [1:0] push_n;

   function automatic rsp_type make_rsp(
      input logic [1:0]  kind,
      input logic [23:0] codes,
      input logic        found,
      input logic        is_ep,
      input logic [3:0]  slot,
      input logic [39:0] cap,
      input logic [4:0]  count,
      input logic [1:0]  status
   );
      rsp_type r;
      r.kind            = kind;
      r.class_code      = codes[7:0];
      r.subclass_code   = codes[15:8];
      r.protocol_code   = codes[23:16];
      r.interface_seen  = found;
      r.ep_slot         = is_ep ? slot : 4'd0;
      r.ep_address      = is_ep ? cap[7:0] : 8'd0;
      r.ep_attributes   = is_ep ? cap[15:8] : 8'd0;
      r.ep_max_packet   = is_ep ? cap[31:16] : 16'd0;
      r.ep_interval     = is_ep ? cap[39:32] : 8'd0;
      r.ep_count        = count;
      r.status_and_last = status;
      return r;
   endfunction

   assign adv       = in_valid_ff && (fifo_cnt_ff <= CntW'(Depth - 2));
   assign req_stall = in_valid_ff && !adv;
   assign rsp_valid = (fifo_cnt_ff != '0);
   assign rsp_data  = fifo_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (adv) begin
         in_valid_in = 1'b0;
      end
   end

   // Walk one byte
   always_comb begin
      logic [7:0]          b;
      logic [EpCntW+4:0]   cnt_wide;
      logic [EpCntW+4:0]   slot_wide;

      b         = in_ff.data_byte;
      pos_in    = pos_ff;
      hdr_in    = hdr_ff;
      len_in    = len_ff;
      dtype_in  = dtype_ff;
      off_in    = off_ff;
      cap_in    = cap_ff;
      stop_in   = stop_ff;
      epcnt_in  = epcnt_ff;
      codes_in  = codes_ff;
      found_in  = found_ff;
      desc_v    = 1'b0;
      sum_v     = 1'b0;
      desc_r    = '0;
      sum_r     = '0;
      cnt_wide  = '0;
      slot_wide = '0;

      if (adv) begin
         if (pos_ff != PosSat) begin
            pos_in = pos_ff + 4'd1;
         end

         if (pos_ff == 4'd0) begin
            hdr_in = ((b < HEADER_MIN) ? HEADER_MIN : b) - 8'd1;
         end else if (hdr_ff != 8'd0) begin
            hdr_in = hdr_ff - 8'd1;
         end else if (!stop_ff) begin
            if (off_ff == 8'd0) begin
               // Length byte: a zero stops the walk, a one is a complete no-op
               if (b == 8'd0) begin
                  stop_in = 1'b1;
               end else begin
                  len_in   = b;
                  dtype_in = 8'd0;
                  cap_in   = '0;
                  if (b != 8'd1) begin
                     off_in = 8'd1;
                  end
               end
            end else begin
               if (off_ff == 8'd1) begin
                  dtype_in = b;
               end else if (dtype_ff == DTYPE_INTERFACE) begin
                  case (off_ff)
                     8'd5:    cap_in[7:0]   = b;
                     8'd6:    cap_in[15:8]  = b;
                     8'd7:    cap_in[23:16] = b;
                     default: cap_in        = cap_ff;
                  endcase
               end else if (dtype_ff == DTYPE_ENDPOINT) begin
                  case (off_ff)
                     8'd2:    cap_in[7:0]   = b;
                     8'd3:    cap_in[15:8]  = b;
                     8'd4:    cap_in[23:16] = b;
                     8'd5:    cap_in[31:24] = b;
                     8'd6:    cap_in[39:32] = b;
                     default: cap_in        = cap_ff;
                  endcase
               end

               if (({1'b0, off_ff} + 9'd1) == {1'b0, len_ff}) begin
                  if (dtype_ff == DTYPE_INTERFACE && len_ff >= IF_LEN_MIN) begin
                     codes_in = cap_in[23:0];
                     found_in = 1'b1;
                     cnt_wide = {5'd0, epcnt_ff};
                     desc_v   = 1'b1;
                     desc_r   = make_rsp(KIND_INTERFACE, codes_in, found_in, 1'b0,
                                         4'd0, '0, cnt_wide[4:0], STATUS_NONE);
                  end else if (dtype_ff == DTYPE_ENDPOINT && len_ff >= EP_LEN_MIN &&
                               epcnt_ff < EpCntW'(MAX_ENDPOINTS)) begin
                     epcnt_in  = epcnt_ff + EpCntW'(1);
                     slot_wide = {5'd0, epcnt_ff};
                     cnt_wide  = {5'd0, epcnt_in};
                     desc_v    = 1'b1;
                     desc_r    = make_rsp(KIND_ENDPOINT, codes_ff, found_ff, 1'b1,
                                          slot_wide[3:0], cap_in, cnt_wide[4:0],
                                          STATUS_NONE);
                  end
                  off_in = 8'd0;
               end else begin
                  off_in = off_ff + 8'd1;
               end
            end
         end

         if (in_ff.last_byte) begin
            sum_v = 1'b1;
            if (pos_in < HEADER_MIN[3:0]) begin
               sum_r = make_rsp(KIND_SUMMARY, '0, 1'b0, 1'b0, 4'd0, '0, 5'd0,
                                STATUS_LAST_SHORT);
            end else begin
               cnt_wide = {5'd0, epcnt_in};
               sum_r    = make_rsp(KIND_SUMMARY, codes_in, found_in, 1'b0, 4'd0, '0,
                                   cnt_wide[4:0], STATUS_LAST_OK);
            end
            // Back to the start of a set
            pos_in   = '0;
            hdr_in   = '0;
            len_in   = '0;
            dtype_in = '0;
            off_in   = '0;
            cap_in   = '0;
            stop_in  = 1'b0;
            epcnt_in = '0;
            codes_in = '0;
            found_in = 1'b0;
         end
      end
   end

   assign push_n  = {1'b0, desc_v} + {1'b0, sum_v};
   assign sum_ptr = desc_v ? (wr_ptr_ff + PtrW'(1)) : wr_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pos_ff      <= '0;
         hdr_ff      <= '0;
         len_ff      <= '0;
         dtype_ff    <= '0;
         off_ff      <= '0;
         cap_ff      <= '0;
         stop_ff     <= 1'b0;
         epcnt_ff    <= '0;
         codes_ff    <= '0;
         found_ff    <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         pos_ff      <= pos_in;
         hdr_ff      <= hdr_in;
         len_ff      <= len_in;
         dtype_ff    <= dtype_in;
         off_ff      <= off_in;
         cap_ff      <= cap_in;
         stop_ff     <= stop_in;
         epcnt_ff    <= epcnt_in;
         codes_ff    <= codes_in;
         found_ff    <= found_in;
         wr_ptr_ff   <= wr_ptr_ff + PtrW'(push_n);
         rd_ptr_ff   <= rd_ptr_ff + PtrW'(pop);
         fifo_cnt_ff <= fifo_cnt_ff + CntW'(push_n) - CntW'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_data;
      end
      // A descriptor result goes ahead of the summary of the same byte
      for (int i = 0; i < Depth; i++) begin
         if (desc_v && wr_ptr_ff == PtrW'(i)) begin
            fifo_ff[i] <= desc_r;
         end else if (sum_v && sum_ptr == PtrW'(i)) begin
            fifo_ff[i] <= sum_r;
         end
      end
   end

   // Checks
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_cnt_ff <= CntW'(Depth))
      else $error("result queue overflow");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (adv && in_ff.last_byte) |=> (pos_ff == 4'd0 && !stop_ff && epcnt_ff == '0))
      else $error("walker state not cleared after final byte");

   a_short_summary: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == KIND_SUMMARY && rsp_data.status_and_last[1])
         |-> (rsp_data.ep_count == 5'd0 && !rsp_data.interface_seen))
      else $error("short set summary reports content");

   a_status_on_summary: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind != KIND_SUMMARY) |-> (rsp_data.status_and_last == STATUS_NONE))
      else $error("status on a non-summary result");

   a_no_push_idle: assert property (@(posedge clock) disable iff (reset)
      !adv |-> (push_n == 2'd0))
      else $error("result pushed without an advancing byte");

endmodule
